// ----- hdl/bbvn_pkg.sv -----
// Shared widths, request and status codes, and the lane control bundle
// for the bounding-box vertex normaliser. No dependencies.
package bbvn_pkg;

  localparam int VERTEX_DEPTH_DEF = 1024;

  localparam int REQ_W    = 2;
  localparam int IDX_W    = 10;
  localparam int COORD_W  = 32;
  localparam int NORM_W   = 18;
  localparam int STATUS_W = 2;
  localparam int AXES     = 3;
  localparam int EXT_W    = 32;
  localparam int QUO_W    = 17;
  localparam int DIV_STEPS = QUO_W;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic clear;
    logic add;
    logic first;
    logic load;
    logic step;
    logic first_step;
  } lane_ctrl_t;

endpackage

// ----- hdl/bbvn_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on bbvn_pkg for field widths.
interface bbvn_req_if;
  import bbvn_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic [IDX_W-1:0]           vertex_index;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  logic signed [COORD_W-1:0]  coord_z;
  modport source (output valid, req_type, vertex_index, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, req_type, vertex_index, coord_x, coord_y, coord_z,
                output ready);
endinterface

interface bbvn_res_if;
  import bbvn_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [NORM_W-1:0]  norm_x;
  logic signed [NORM_W-1:0]  norm_y;
  logic signed [NORM_W-1:0]  norm_z;
  logic [STATUS_W-1:0]       status;
  modport source (output valid, norm_x, norm_y, norm_z, status, input ready);
  modport sink (input valid, norm_x, norm_y, norm_z, status, output ready);
endinterface

// ----- hdl/bbvn_lane.sv -----
// One axis lane: tracks the axis minimum and maximum, and runs a restoring
// divider that scales a centred coordinate by the largest extent. Uses bbvn_pkg.
module bbvn_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  bbvn_pkg::lane_ctrl_t                ctrl,
  input  logic signed [bbvn_pkg::COORD_W-1:0] coord,
  input  logic signed [bbvn_pkg::COORD_W-1:0] vert,
  input  logic [bbvn_pkg::EXT_W-1:0]          ext_max,
  output logic [bbvn_pkg::EXT_W-1:0]          extent,
  output logic signed [bbvn_pkg::NORM_W-1:0]  norm
);
  import bbvn_pkg::*;

  logic signed [COORD_W-1:0] amin;
  logic signed [COORD_W-1:0] amax;
  logic signed [COORD_W:0]   mid_sum;
  logic [EXT_W-1:0]          rem;
  logic [QUO_W-1:0]          quo;
  logic                      neg;

  logic signed [COORD_W+1:0] diff;
  logic [COORD_W+1:0]        mag;
  logic [EXT_W:0]            trial;
  logic                      take;
  logic [EXT_W:0]            rest;
  logic                      round_up;
  logic [NORM_W-1:0]         q_round;

  always_ff @(posedge clk) begin
    if (rst) begin
      amin <= '0;
      amax <= '0;
    end else if (ctrl.clear) begin
      amin <= '0;
      amax <= '0;
    end else if (ctrl.add) begin
      if (ctrl.first) begin
        amin <= coord;
        amax <= coord;
      end else begin
        if (coord < amin) amin <= coord;
        if (coord > amax) amax <= coord;
      end
    end
  end

  // Midpoint sum and extent are registered from the bounds
  always_ff @(posedge clk) begin
    mid_sum <= {amin[COORD_W-1], amin} + {amax[COORD_W-1], amax};
    extent  <= EXT_W'({amax[COORD_W-1], amax} - {amin[COORD_W-1], amin});
  end

  always_comb begin
    diff  = ({vert[COORD_W-1], vert, 1'b0}) - {mid_sum[COORD_W], mid_sum};
    mag   = diff[COORD_W+1] ? -diff : diff;
    trial = ctrl.first_step ? {1'b0, rem} : {rem, 1'b0};
    take  = trial >= {1'b0, ext_max};
    rest  = take ? trial - {1'b0, ext_max} : trial;
  end

  // |2v - m| never exceeds the extent, so the magnitude fits the remainder
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= mag[EXT_W-1:0];
      neg <= diff[COORD_W+1];
      quo <= '0;
    end else if (ctrl.step) begin
      rem <= rest[EXT_W-1:0];
      quo <= {quo[QUO_W-2:0], take};
    end
  end

  // Round to nearest, ties away from zero: bump when twice the remainder reaches the divisor
  always_comb begin
    round_up = {rem, 1'b0} >= {1'b0, ext_max};
    q_round  = NORM_W'(quo) + NORM_W'(round_up);
    norm     = neg ? signed'(NORM_W'(0) - q_round) : signed'(q_round);
  end

endmodule

// ----- hdl/bbvn_merge.sv -----
// Merging stage: picks the largest axis extent over the lanes and flags a
// degenerate box. Uses bbvn_pkg.
module bbvn_merge (
  input  logic                       clk,
  input  logic [bbvn_pkg::EXT_W-1:0] extent [bbvn_pkg::AXES],
  output logic [bbvn_pkg::EXT_W-1:0] ext_max,
  output logic                       ext_zero
);
  import bbvn_pkg::*;

  logic [EXT_W-1:0] best;

  always_comb begin
    best = '0;
    for (int i = 0; i < AXES; i++) begin
      if (extent[i] > best) best = extent[i];
    end
  end

  always_ff @(posedge clk) begin
    ext_max  <= best;
    ext_zero <= (best == '0);
  end

endmodule

// ----- hdl/bounding_box_vertex_normalizer.sv -----
// Bounding-box vertex normaliser, top level.
// Channels: req (sink) carries clear, add and read requests; res (source)
// returns one result per add or read, none for a clear or an unused code.
// A read returns the stored vertex centred on the box midpoint and scaled by
// 2 over the largest extent, in signed Q1.16, with a status code.
// A read runs a memory read, an extent check, 17 restoring divide steps run
// in three axis lanes side by side, rounding and a result load. An add or an
// out-of-range read goes straight to its result; a zero-extent read ends
// after its extent check. The divider sets the read rate.
// One request is worked at a time; req.ready is high when the block is idle,
// also while a finished result still waits in the output register.
// A stalled receiver holds the result in the output register; the next
// result waits in its pending stage until the output register frees.
// Reset empties the store count and zeroes the bounds; the vertex memory is
// not cleared, since only entries below the count are ever read.
// Depends on bbvn_pkg, bbvn_if, bbvn_lane and bbvn_merge.
module bounding_box_vertex_normalizer #(
  parameter int VERTEX_DEPTH = bbvn_pkg::VERTEX_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  bbvn_req_if.sink  req,
  bbvn_res_if.source res
);
  import bbvn_pkg::*;

  localparam int AW     = $clog2(VERTEX_DEPTH);
  localparam int CW     = $clog2(VERTEX_DEPTH + 1);
  localparam int CMPW   = (CW > IDX_W) ? CW : IDX_W;
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam int VW     = AXES * COORD_W;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]        state;
  logic [CW-1:0]     count;
  logic [STEP_W-1:0] step_cnt;
  logic              out_valid;

  logic [VW-1:0]     mem [VERTEX_DEPTH];
  logic [VW-1:0]     rd_data;

  logic [STATUS_W-1:0]      pend_status;
  logic signed [NORM_W-1:0] pend_norm [AXES];
  logic [STATUS_W-1:0]      out_status;
  logic signed [NORM_W-1:0] out_norm [AXES];

  logic                      acc;
  logic                      full;
  logic                      in_range;
  logic                      out_load;
  logic [CMPW-1:0]           idx_ext;
  logic                      is_add;
  logic                      is_read;
  lane_ctrl_t                ctrl;
  logic signed [COORD_W-1:0] add_coord [AXES];
  logic signed [NORM_W-1:0]  lane_norm [AXES];
  logic [EXT_W-1:0]          lane_ext [AXES];
  logic [EXT_W-1:0]          ext_max;
  logic                      ext_zero;

  assign acc      = req.valid && req.ready;
  assign full     = (count == CW'(VERTEX_DEPTH));
  assign idx_ext  = CMPW'(req.vertex_index);
  assign in_range = idx_ext < CMPW'(count);
  assign is_add   = (req.req_type == REQ_ADD);
  assign is_read  = (req.req_type == REQ_READ);
  assign out_load = (state == S_EMIT) && (!out_valid || res.ready);

  assign req.ready  = (state == S_IDLE);
  assign res.valid  = out_valid;
  assign res.norm_x = out_norm[0];
  assign res.norm_y = out_norm[1];
  assign res.norm_z = out_norm[2];
  assign res.status = out_status;

  assign add_coord[0] = req.coord_x;
  assign add_coord[1] = req.coord_y;
  assign add_coord[2] = req.coord_z;

  always_comb begin
    ctrl.clear      = acc && (req.req_type == REQ_CLEAR);
    ctrl.add        = acc && is_add && !full;
    ctrl.first      = (count == '0);
    ctrl.load       = (state == S_CHECK) && !ext_zero;
    ctrl.step       = (state == S_DIV);
    ctrl.first_step = (step_cnt == '0);
  end

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    bbvn_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .coord   (add_coord[i]),
      .vert    (rd_data[i*COORD_W +: COORD_W]),
      .ext_max (ext_max),
      .extent  (lane_ext[i]),
      .norm    (lane_norm[i])
    );
  end

  bbvn_merge u_merge (
    .clk      (clk),
    .extent   (lane_ext),
    .ext_max  (ext_max),
    .ext_zero (ext_zero)
  );

  // Vertex memory: one write port for adds, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.add) begin
      mem[count[AW-1:0]] <= {req.coord_z, req.coord_y, req.coord_x};
    end
    if (acc && is_read) begin
      rd_data <= mem[idx_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            case (req.req_type)
              REQ_CLEAR: count <= '0;
              REQ_ADD: begin
                if (!full) count <= count + CW'(1);
                state <= S_EMIT;
              end
              REQ_READ: state <= in_range ? S_LOAD : S_EMIT;
              default: ;
            endcase
          end
        end
        S_LOAD: state <= S_CHECK;
        S_CHECK: begin
          if (ext_zero) begin
            state <= S_EMIT;
          end else begin
            state    <= S_DIV;
            step_cnt <= '0;
          end
        end
        S_DIV: begin
          if (step_cnt == STEP_LAST) begin
            state <= S_ROUND;
          end else begin
            step_cnt <= step_cnt + STEP_W'(1);
          end
        end
        S_ROUND: state <= S_EMIT;
        S_EMIT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Pending result and output register
  always_ff @(posedge clk) begin
    if (acc && is_add) begin
      pend_status <= full ? ST_FULL : ST_OK;
      for (int i = 0; i < AXES; i++) pend_norm[i] <= '0;
    end else if (acc && is_read && !in_range) begin
      pend_status <= ST_RANGE;
      for (int i = 0; i < AXES; i++) pend_norm[i] <= '0;
    end else if ((state == S_CHECK) && ext_zero) begin
      pend_status <= ST_ZERO;
      for (int i = 0; i < AXES; i++) pend_norm[i] <= '0;
    end else if (state == S_ROUND) begin
      pend_status <= ST_OK;
      for (int i = 0; i < AXES; i++) pend_norm[i] <= lane_norm[i];
    end
    if (out_load) begin
      out_status <= pend_status;
      for (int i = 0; i < AXES; i++) out_norm[i] <= pend_norm[i];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(VERTEX_DEPTH))
    else $error("vertex count beyond store depth");

  a_full_add_kept: assert property (@(posedge clk) disable iff (rst)
    (acc && is_add && full) |=> (count == $past(count)))
    else $error("add to a full store changed the count");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (acc && (req.req_type == REQ_CLEAR)) |=> (count == '0))
    else $error("clear left vertices in the store");

  a_div_to_round: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIV) && (step_cnt == STEP_LAST)) |=> (state == S_ROUND))
    else $error("divider ran past its last step");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && out_valid && !res.ready) |=> (state == S_EMIT))
    else $error("pending result dropped while receiver stalled");

endmodule
